// ===== hw/rtl/quadratic_root_solver_defines.svh =====
// assertion macros for the quadratic root solver checker
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qrs_pkg.sv =====
// shared constants for the quadratic root solver
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS      = 16;
    localparam int OUT_WIDTH      = 34;
endpackage
`default_nettype wire

// ===== hw/rtl/qrs_if.sv =====
// valid/ready channel interfaces for coefficients and roots
`timescale 1ns / 1ps
`default_nettype none
interface qrs_coef_if #(parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
    logic                                valid;
    logic                                ready;
    logic signed [qrs_pkg::OUT_WIDTH-1:0] root_one_real;
    logic signed [qrs_pkg::OUT_WIDTH-1:0] root_two_real;
    logic signed [qrs_pkg::OUT_WIDTH-1:0] imag_part;
    logic                                is_complex;
    modport source (output valid, root_one_real, root_two_real, imag_part, is_complex,
                    input ready);
    modport sink   (input valid, root_one_real, root_two_real, imag_part, is_complex,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/quadratic_root_solver.sv =====
// top level of the pipelined fixed-point quadratic root solver
// pipeline: 2 front-end stages, COEF_WIDTH+17 square-root stages,
// COEF_WIDTH+17 divider stages, 1 output register
// throughput: one beat per cycle; the whole pipe advances whenever the output
// register is empty or being taken
// reset: asynchronous active-low, clears only the stage valid bits
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    qrs_coef_if.sink    coef,
    qrs_root_if.source  roots
);
    localparam int W   = COEF_WIDTH;
    localparam int F   = qrs_pkg::FRAC_BITS;
    localparam int OW  = qrs_pkg::OUT_WIDTH;
    localparam int MW  = 2 * W + 1;       // |discriminant|
    localparam int N   = W + F + 1;       // root and scaled -b magnitude
    localparam int DW  = W + 1;           // |2a|
    localparam int SW  = N + 2;           // signed sums of quotients
    localparam int EW  = (SW > OW) ? SW : OW;
    localparam int SQ_SIDE = N + DW + 3;

    // global advance: a stall freezes every stage at once
    logic en;

    // front end outputs
    logic          d_valid;
    logic [MW-1:0] d_mag;
    logic [N-1:0]  d_re_num;
    logic [DW-1:0] d_divisor;
    logic          d_re_neg;
    logic          d_im_neg;
    logic          d_cplx;

    // square root outputs
    logic               s_valid;
    logic [N-1:0]       s_root;
    logic [SQ_SIDE-1:0] s_side;

    // divider outputs
    logic         q_valid;
    logic [N-1:0] q_re;
    logic [N-1:0] q_im;
    logic [1:0]   q_re_side;
    logic         q_im_neg;

    // output assembly
    logic signed [N:0]    re_s;
    logic signed [N:0]    im_s;
    logic signed [SW-1:0] sum_minus;
    logic signed [SW-1:0] sum_plus;
    logic signed [EW-1:0] ext_minus;
    logic signed [EW-1:0] ext_plus;
    logic signed [EW-1:0] ext_re;
    logic signed [EW-1:0] ext_im;

    logic                 out_vld_reg;
    logic signed [OW-1:0] one_reg;
    logic signed [OW-1:0] two_reg;
    logic signed [OW-1:0] imag_reg;
    logic                 cplx_reg;

    assign en         = !out_vld_reg || roots.ready;
    assign coef.ready = en;

    // stage 1-2: products, discriminant, magnitudes and result signs
    qrs_disc #(
        .COEF_WIDTH (W)
    ) u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef.valid),
        .coef_a    (coef.coef_a),
        .coef_b    (coef.coef_b),
        .coef_c    (coef.coef_c),
        .out_valid (d_valid),
        .mag       (d_mag),
        .re_num    (d_re_num),
        .divisor   (d_divisor),
        .re_neg    (d_re_neg),
        .im_neg    (d_im_neg),
        .cplx      (d_cplx)
    );

    // floor(sqrt(|D| * 2^32)); the real-part numerator rides along
    qrs_sqrt #(
        .MW     (MW),
        .RW     (N),
        .SIDE_W (SQ_SIDE)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .mag       (d_mag),
        .in_side   ({d_re_num, d_divisor, d_re_neg, d_im_neg, d_cplx}),
        .out_valid (s_valid),
        .root      (s_root),
        .out_side  (s_side)
    );

    // both quotients in lockstep over the same divisor |2a|
    qrs_div #(
        .N      (N),
        .DW     (DW),
        .SIDE_W (2)
    ) u_div_re (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .num       (s_side[SQ_SIDE-1 -: N]),
        .den       (s_side[DW+2:3]),
        .in_side   ({s_side[2], s_side[0]}),
        .out_valid (q_valid),
        .quot      (q_re),
        .out_side  (q_re_side)
    );

    qrs_div #(
        .N      (N),
        .DW     (DW),
        .SIDE_W (1)
    ) u_div_im (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .num       (s_root),
        .den       (s_side[DW+2:3]),
        .in_side   (s_side[1]),
        .out_valid (),
        .quot      (q_im),
        .out_side  (q_im_neg)
    );

    // truncating division: apply signs to magnitudes, then combine
    always_comb
    begin
        re_s      = q_re_side[1] ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
        im_s      = q_im_neg ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});
        sum_minus = SW'(re_s) - SW'(im_s);
        sum_plus  = SW'(re_s) + SW'(im_s);
        ext_minus = EW'(sum_minus);
        ext_plus  = EW'(sum_plus);
        ext_re    = EW'(re_s);
        ext_im    = EW'(im_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= q_valid;
    end

    // complex roots share the real part; real roots carry no imaginary term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cplx_reg <= q_re_side[0];
            if (q_re_side[0])
            begin
                one_reg  <= ext_re[OW-1:0];
                two_reg  <= ext_re[OW-1:0];
                imag_reg <= ext_im[OW-1:0];
            end
            else
            begin
                one_reg  <= ext_minus[OW-1:0];
                two_reg  <= ext_plus[OW-1:0];
                imag_reg <= '0;
            end
        end
    end

    assign roots.valid         = out_vld_reg;
    assign roots.root_one_real = one_reg;
    assign roots.root_two_real = two_reg;
    assign roots.imag_part     = imag_reg;
    assign roots.is_complex    = cplx_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/qrs_disc.sv =====
// two-stage front end: products, discriminant, magnitudes and signs
`timescale 1ns / 1ps
`default_nettype none
module qrs_disc #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire  signed [COEF_WIDTH-1:0] coef_a,
    input  wire  signed [COEF_WIDTH-1:0] coef_b,
    input  wire  signed [COEF_WIDTH-1:0] coef_c,
    output logic                         out_valid,
    output logic [2*COEF_WIDTH:0]        mag,
    output logic [COEF_WIDTH+16:0]       re_num,
    output logic [COEF_WIDTH:0]          divisor,
    output logic                         re_neg,
    output logic                         im_neg,
    output logic                         cplx
);
    localparam int W  = COEF_WIDTH;
    localparam int F  = qrs_pkg::FRAC_BITS;
    localparam int MW = 2 * W + 1;
    localparam int N  = W + F + 1;
    localparam int DW = W + 1;
    localparam int XW = 2 * W + 3;

    logic                  vld_a_reg;
    logic signed [2*W-1:0] bb_reg;
    logic signed [2*W-1:0] ac_reg;
    logic signed [W-1:0]   b_reg;
    logic signed [W-1:0]   a_reg;
    logic signed [W-1:0]   a_eff;

    logic signed [XW-1:0]  disc;
    logic [XW-1:0]         disc_abs;
    logic [W-1:0]          b_abs;
    logic [W-1:0]          a_abs;

    logic                  vld_b_reg;
    logic [MW-1:0]         mag_reg;
    logic [N-1:0]          re_num_reg;
    logic [DW-1:0]         divisor_reg;
    logic                  re_neg_reg;
    logic                  im_neg_reg;
    logic                  cplx_reg;

    // zero a is taken as one
    assign a_eff = (coef_a == '0) ? W'(1) : coef_a;

    always_comb
    begin
        disc     = XW'(bb_reg) - (XW'(ac_reg) <<< 2);
        disc_abs = disc[XW-1] ? XW'(-disc) : XW'(disc);
        b_abs    = b_reg[W-1] ? W'(-b_reg) : W'(b_reg);
        a_abs    = a_reg[W-1] ? W'(-a_reg) : W'(a_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg      <= coef_b * coef_b;
            ac_reg      <= a_eff * coef_c;
            b_reg       <= coef_b;
            a_reg       <= a_eff;
            mag_reg     <= disc_abs[MW-1:0];
            re_num_reg  <= N'({b_abs, {F{1'b0}}});
            divisor_reg <= {a_abs, 1'b0};
            // -b over a: negative when b positive xor a negative
            re_neg_reg  <= (!b_reg[W-1] && (b_reg != '0)) ^ a_reg[W-1];
            im_neg_reg  <= a_reg[W-1];
            cplx_reg    <= disc[XW-1];
        end
    end

    assign out_valid = vld_b_reg;
    assign mag       = mag_reg;
    assign re_num    = re_num_reg;
    assign divisor   = divisor_reg;
    assign re_neg    = re_neg_reg;
    assign im_neg    = im_neg_reg;
    assign cplx      = cplx_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/qrs_sqrt.sv =====
// pipelined integer square root of mag * 2^32, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt #(
    parameter int MW     = 33,
    parameter int RW     = 33,
    parameter int SIDE_W = 1
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               en,
    input  wire               in_valid,
    input  wire  [MW-1:0]     mag,
    input  wire  [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RW-1:0]     root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int RADW = 2 * RW;
    localparam int SH   = 2 * qrs_pkg::FRAC_BITS;

    logic              vld [0:RW];
    logic [RW-1:0]     rt  [0:RW];
    logic [RW+1:0]     rm  [0:RW];
    logic [RADW-1:0]   rad [0:RW];
    logic [SIDE_W-1:0] sd  [0:RW];

    assign vld[0] = in_valid;
    assign rt[0]  = '0;
    assign rm[0]  = '0;
    assign rad[0] = RADW'({mag, {SH{1'b0}}});
    assign sd[0]  = in_side;

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [RW+1:0] cat;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          take;

        always_comb
        begin
            cat   = {rm[i][RW-1:0], rad[i][RADW-1 -: 2]};
            trial = {rt[i], 2'b01};
            take  = (cat >= trial);
            diff  = cat - trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld[i+1] <= 1'b0;
            else if (en)
                vld[i+1] <= vld[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt[i+1]  <= {rt[i][RW-2:0], take};
                rm[i+1]  <= take ? diff : cat;
                rad[i+1] <= rad[i] << 2;
                sd[i+1]  <= sd[i];
            end
        end
    end

    assign out_valid = vld[RW];
    assign root      = rt[RW];
    assign out_side  = sd[RW];
endmodule
`default_nettype wire

// ===== hw/rtl/qrs_div.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module qrs_div #(
    parameter int N      = 33,
    parameter int DW     = 17,
    parameter int SIDE_W = 1
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               en,
    input  wire               in_valid,
    input  wire  [N-1:0]      num,
    input  wire  [DW-1:0]     den,
    input  wire  [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [N-1:0]      quot,
    output logic [SIDE_W-1:0] out_side
);
    logic              vld [0:N];
    logic [N-1:0]      nq  [0:N];
    logic [DW-1:0]     rm  [0:N];
    logic [DW-1:0]     dv  [0:N];
    logic [SIDE_W-1:0] sd  [0:N];

    assign vld[0] = in_valid;
    assign nq[0]  = num;
    assign rm[0]  = '0;
    assign dv[0]  = den;
    assign sd[0]  = in_side;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [DW:0] cat;
        logic [DW:0] diff;
        logic        take;

        always_comb
        begin
            cat  = {rm[i], nq[i][N-1]};
            take = (cat >= {1'b0, dv[i]});
            diff = cat - {1'b0, dv[i]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld[i+1] <= 1'b0;
            else if (en)
                vld[i+1] <= vld[i];
        end

        // quotient bits shift in where numerator bits shift out
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq[i+1] <= {nq[i][N-2:0], take};
                rm[i+1] <= take ? diff[DW-1:0] : cat[DW-1:0];
                dv[i+1] <= dv[i];
                sd[i+1] <= sd[i];
            end
        end
    end

    assign out_valid = vld[N];
    assign quot      = nq[N];
    assign out_side  = sd[N];
endmodule
`default_nettype wire

// ===== hw/rtl/qrs_checker.sv =====
// port-level checks for the quadratic root solver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_root_solver_defines.svh"
module qrs_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [qrs_pkg::OUT_WIDTH-1:0] one_real,
    input wire [qrs_pkg::OUT_WIDTH-1:0] two_real,
    input wire [qrs_pkg::OUT_WIDTH-1:0] imag,
    input wire                         is_complex
);
    `QRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
    `QRS_ASSERT_NOW(a_stall_back, out_valid && !out_ready, !in_ready, "input taken while output stalled")
    `QRS_ASSERT_NOW(a_real_no_imag, out_valid && !is_complex, imag == '0, "real roots with imaginary term")
    `QRS_ASSERT_NOW(a_cplx_pair, out_valid && is_complex, one_real == two_real, "complex roots differ in real part")
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (coef.ready),
    .out_valid  (roots.valid),
    .out_ready  (roots.ready),
    .one_real   (roots.root_one_real),
    .two_real   (roots.root_two_real),
    .imag       (roots.imag_part),
    .is_complex (roots.is_complex)
);
`default_nettype wire

// ===== tb/tb_quadratic_root_solver.sv =====
// self-checking regression bench for the quadratic root solver
`timescale 1ns / 1ps
`default_nettype none
module tb_quadratic_root_solver;
    localparam int CW         = qrs_pkg::COEF_WIDTH_DEF;
    localparam int PIPE_DEPTH = 2 * CW + 37;   // sum of the stages listed at the block head
    localparam int CYCLE_CAP  = 400000;        // watchdog limit on simulated cycles

    typedef logic signed [CW-1:0]                 coef_t;
    typedef logic signed [qrs_pkg::OUT_WIDTH-1:0] fix_t;

    // one expected beat on the root channel
    typedef struct packed {
        fix_t root_lo;
        fix_t root_hi;
        fix_t imag;
        logic cplx;
    } root_set_t;

    logic clk;
    logic rst_n;

    qrs_coef_if #(.COEF_WIDTH(CW)) coef ();
    qrs_root_if                    roots ();

    quadratic_root_solver #(.COEF_WIDTH(CW)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef),
        .roots (roots)
    );

    root_set_t pending_roots[$];   // roots owed by the block, oldest first
    int        mismatches;
    int        cycle_count;
    int        burst_left;         // beats left in the current sender burst
    int        hold_cycles;        // long receiver hold-off, counted down below
    int        hold_request;
    int        stall_style;

    // clock, period 10 ns
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor: discriminant, scaled integer square root, then the two
    // truncating divisions by 2a; outputs keep their low 34 bits
    // ------------------------------------------------------------------
    function automatic root_set_t solve_roots(coef_t a_in, coef_t b_in, coef_t c_in);
        longint     a, b, c, two_a, disc, re, im;
        bit [127:0] radicand;
        bit [127:0] square;
        bit [63:0]  root;
        bit [63:0]  trial;
        root_set_t  res;
        a = a_in;
        b = b_in;
        c = c_in;
        // zero leading coefficient is taken as one
        if (a == 0)
            a = 1;
        two_a = 2 * a;
        disc  = b * b - 4 * a * c;
        radicand = {64'b0, ((disc < 0) ? -disc : disc)} << 32;
        root = '0;
        for (int k = 62; k >= 0; k--)
        begin
            trial  = root | (64'd1 << k);
            square = {64'b0, trial} * {64'b0, trial};
            if (square <= radicand)
                root = trial;
        end
        // longint division truncates toward zero, as the block does
        re = (-b * 65536) / two_a;
        im = longint'(root) / two_a;
        if (disc < 0)
        begin
            res.root_lo = fix_t'(re);
            res.root_hi = fix_t'(re);
            res.imag    = fix_t'(im);
            res.cplx    = 1'b1;
        end
        else
        begin
            res.root_lo = fix_t'(re - im);
            res.root_hi = fix_t'(re + im);
            res.imag    = '0;
            res.cplx    = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // sender: one beat per call; valid stays up through a burst and
    // drops only for the random gap, when one is drawn, that ends a burst
    // ------------------------------------------------------------------
    task automatic send_coefs(coef_t a, coef_t b, coef_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                coef.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        coef.valid  <= 1'b1;
        coef.coef_a <= a;
        coef.coef_b <= b;
        coef.coef_c <= c;
        // wait for the handshake at a rising edge
        do
            @(posedge clk);
        while (!coef.ready);
        pending_roots.push_back(solve_roots(a, b, c));
        @(negedge clk);
    endtask

    task automatic send_random();
        send_coefs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
    endtask

    // ------------------------------------------------------------------
    // receiver: ready follows a changing stall style, overridden by the
    // long hold-off when one is requested
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_cycles  <= hold_request;
            hold_request <= 0;
            roots.ready  <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            roots.ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0: roots.ready <= 1'b1;                          // no stalls
                1: roots.ready <= $urandom_range(0, 1) == 1;     // coin flip
                2: roots.ready <= $urandom_range(0, 7) != 0;     // rare stalls
                default: roots.ready <= $urandom_range(0, 3) == 0; // mostly stalled
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker, sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        root_set_t want;
        if (rst_n && roots.valid && roots.ready)
        begin
            if (pending_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected root beat: %0d %0d %0d %0b", roots.root_one_real,
                             roots.root_two_real, roots.imag_part, roots.is_complex);
            end
            else
            begin
                want = pending_roots.pop_front();
                if (roots.root_one_real !== want.root_lo || roots.root_two_real !== want.root_hi
                    || roots.imag_part !== want.imag || roots.is_complex !== want.cplx)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("root mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                 want.root_lo, want.root_hi, want.imag, want.cplx,
                                 roots.root_one_real, roots.root_two_real,
                                 roots.imag_part, roots.is_complex);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("quadratic_root_solver regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // coefficient extremes: rotations of the field limits and of plus and minus one
    task automatic test_extremes();
        coef_t lim[4];
        lim[0] = coef_t'(-32768);
        lim[1] = coef_t'(32767);
        lim[2] = coef_t'(-1);
        lim[3] = coef_t'(1);
        for (int i = 0; i < 4; i++)
            send_coefs(lim[i], lim[(i + 1) % 4], lim[(i + 2) % 4]);
        send_coefs(coef_t'(-32768), coef_t'(-32768), coef_t'(32767));   // widest discriminant
        send_coefs(coef_t'(32767), coef_t'(-32768), coef_t'(32767));    // complex, limits on every field
        send_coefs(coef_t'(1), coef_t'(-32768), coef_t'(0));            // largest real part
    endtask

    // zero leading coefficient stands in for one
    task automatic test_zero_a();
        send_coefs('0, '0, '0);
        send_coefs('0, coef_t'(5), coef_t'(-6));
        send_coefs('0, coef_t'(-32768), coef_t'(-32768));
        send_coefs('0, coef_t'(1), coef_t'(32767));
    endtask

    // real, repeated and complex roots, both signs of a
    task automatic test_root_kinds();
        send_coefs(coef_t'(1), coef_t'(-3), coef_t'(2));      // distinct real
        send_coefs(coef_t'(1), coef_t'(2), coef_t'(1));       // double root
        send_coefs(coef_t'(1), coef_t'(0), coef_t'(1));       // pure imaginary
        send_coefs(coef_t'(-2), coef_t'(3), coef_t'(-5));     // complex, negative a
        send_coefs(coef_t'(-3), coef_t'(7), coef_t'(11));     // real, negative a
        send_coefs(coef_t'(3), coef_t'(1), coef_t'(-1));      // irrational real
        send_coefs(coef_t'(7), coef_t'(-1), coef_t'(0));      // truncated real part
    endtask

    // broad random coverage; a share with small coefficients lands on
    // more exact and near-zero discriminants
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_coefs(coef_t'($urandom_range(0, 16) - 8), coef_t'($urandom_range(0, 32) - 16),
                           coef_t'($urandom_range(0, 16) - 8));
            else
                send_random();
        end
    endtask

    // receiver holds off long enough for the pipe to fill and stall input
    task automatic test_backpressure();
        hold_request = 4 * PIPE_DEPTH;
        for (int i = 0; i < 3 * PIPE_DEPTH; i++)
            send_random();
    endtask

    initial
    begin
        mismatches   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        hold_cycles  = 0;
        hold_request = 0;
        stall_style  = 0;
        rst_n        = 1'b0;
        coef.valid   = 1'b0;
        coef.coef_a  = '0;
        coef.coef_b  = '0;
        coef.coef_c  = '0;
        roots.ready  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_zero_a();
        test_root_kinds();
        test_backpressure();
        test_random(1710);

        coef.valid <= 1'b0;
        wait (pending_roots.size() == 0);
        repeat (PIPE_DEPTH + 20) @(posedge clk);

        if (mismatches == 0 && pending_roots.size() == 0)
            $display("quadratic_root_solver regression: pass");
        else
            $display("quadratic_root_solver regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_if.sv
hw/rtl/qrs_disc.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver.sv
hw/rtl/qrs_checker.sv
tb/tb_quadratic_root_solver.sv
